[sv/arlt_pkg.sv]
package arlt_pkg;

   localparam int HISTORY_DEPTH_DEF      = 16;
   localparam int MAX_WINDOW_SAMPLES_DEF = 4095;

   localparam int SAMPLE_W  = 10;
   localparam int LEVEL_W   = 14;
   localparam int BRIGHT_W  = 8;
   localparam int HLEN_W    = 5;
   localparam int SUM_W     = 33;
   localparam int RAD_W     = 28;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [LEVEL_W-1:0]  MIDSCALE_Q4 = 14'd8192;
   localparam logic [BRIGHT_W-1:0] FULL_BRIGHT = 8'd255;
   localparam logic [HLEN_W-1:0]   HLEN_RESET  = 5'd16;

   // register index, taken from paddr[3:2]
   localparam logic [1:0] REG_NOISE_FLOOR = 2'd0;
   localparam logic [1:0] REG_MIN_MAX     = 2'd1;
   localparam logic [1:0] REG_HIST_LEN    = 2'd2;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_DIV   = 8'b0000_0010,
      ST_SQRT  = 8'b0000_0100,
      ST_LEVEL = 8'b0000_1000,
      ST_WALK  = 8'b0001_0000,
      ST_SCALE = 8'b0010_0000,
      ST_PUSH  = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

endpackage

[sv/audio_rms_level_tracker.sv]
// A sample without tlast is added to the window sum and count when accepted. A window-end
// sample starts the sequence: 33-step mean division, 14-step square root, a walk over the
// history entries in use, 33-step brightness division (skipped on a flat mapping range),
// history push, then the result, held while rsp_tready stalls. Throughput: one sample per
// cycle between window ends, ready low during the sequence. Synchronous active-high reset
// clears accumulators, fill, output valid, noise floor and min-max; history length is 16.
module audio_rms_level_tracker #(
   parameter int HISTORY_DEPTH      = arlt_pkg::HISTORY_DEPTH_DEF,
   parameter int MAX_WINDOW_SAMPLES = arlt_pkg::MAX_WINDOW_SAMPLES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // sample stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // [9:0] sample
   input  logic        req_tlast,    // last_of_window
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // [13:0] level, [21:14] brightness
   output logic        rsp_tuser,    // [0] louder
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [arlt_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [arlt_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [arlt_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   localparam int SW     = arlt_pkg::SAMPLE_W;
   localparam int LW     = arlt_pkg::LEVEL_W;
   localparam int BW     = arlt_pkg::BRIGHT_W;
   localparam int SUM_W  = arlt_pkg::SUM_W;
   localparam int RAD_W  = arlt_pkg::RAD_W;
   localparam int CNT_W  = $clog2(MAX_WINDOW_SAMPLES + 1);
   localparam int DIV_W  = (CNT_W > SW) ? CNT_W : SW;
   localparam int DCNT_W = $clog2(SUM_W + 1);
   localparam int PTR_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);

   localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_WINDOW_SAMPLES);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);
   localparam logic [FILL_W-1:0] LEN_MAX = FILL_W'(HISTORY_DEPTH);
   localparam logic [RAD_W-1:0] BIT_TOP  = RAD_W'(1) << (RAD_W - 2);

   // ---------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------
   arlt_pkg::state_type state_ff, state_in;

   logic [SW-1:0]                  noise_floor_ff, noise_floor_in;
   logic [SW-1:0]                  min_max_ff, min_max_in;
   logic [arlt_pkg::HLEN_W-1:0]    hist_len_ff, hist_len_in;

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // shared restoring divider
   logic [DIV_W-1:0]  div_rem_ff, div_rem_in;
   logic [SUM_W-1:0]  div_quo_ff, div_quo_in;
   logic [DIV_W-1:0]  div_den_ff, div_den_in;
   logic [DCNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic              div_bright_ff, div_bright_in;

   // square root
   logic [RAD_W-1:0] sq_val_ff, sq_val_in;
   logic [RAD_W-1:0] sq_res_ff, sq_res_in;
   logic [RAD_W-1:0] sq_bit_ff, sq_bit_in;

   logic [LW-1:0] level_ff, level_in;
   logic [LW-1:0] lo_ff, lo_in;
   logic [LW-1:0] hi_ff, hi_in;
   logic          louder_ff, louder_in;
   logic [BW-1:0] bright_ff, bright_in;

   // history
   logic [PTR_W-1:0]  newest_ff, newest_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [PTR_W-1:0]  walk_ptr_ff, walk_ptr_in;
   logic [FILL_W-1:0] walk_left_ff, walk_left_in;
   logic              pend_ff, pend_in;
   logic              first_ff, first_in;
   logic              started_ff, started_in;
   logic [LW-1:0]     mem_q_ff;
   logic [LW-1:0]     hist_mem [HISTORY_DEPTH];

   logic          rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0] rsp_level_ff, rsp_level_in;
   logic [BW-1:0] rsp_bright_ff, rsp_bright_in;
   logic          rsp_louder_ff, rsp_louder_in;

   // ---------------------------------------------------------------------------
   // Combinational helpers
   // ---------------------------------------------------------------------------
   logic               csr_write;
   logic [1:0]         csr_index;
   logic               in_accept;
   logic [SW-1:0]      sample;
   logic [2*SW-1:0]    square;
   logic [SUM_W:0]     sum_wide;
   logic [SUM_W-1:0]   sum_next;
   logic [CNT_W-1:0]   count_next;
   logic [DIV_W:0]     div_trial;
   logic               div_take;
   logic [RAD_W-1:0]   sq_try;
   logic [LW-1:0]      root;
   logic [LW-1:0]      dev;
   logic [LW-1:0]      noise_q4;
   logic [FILL_W-1:0]  len_eff;
   logic [FILL_W-1:0]  used;
   logic               mem_rd;
   logic               mem_wr;
   logic [PTR_W-1:0]   newest_inc;
   logic [FILL_W:0]    fill_inc;
   logic [SW-1:0]      xi, mn, mx, hi_int;
   logic [SW-1:0]      span;
   logic [SW+BW-1:0]   numer;

   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_index = csr_paddr[3:2];
   assign csr_pready = 1'b1;
   assign in_accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == arlt_pkg::ST_IDLE);
   assign sample = req_tdata[SW-1:0];

   assign square   = sample * sample;
   assign sum_wide = {1'b0, sum_ff} + {{(SUM_W + 1 - 2*SW){1'b0}}, square};

   // saturate the sum, stop counting once the window count is full
   always_comb begin
      if (count_ff < CNT_MAX) begin
         sum_next   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
         count_next = count_ff + CNT_W'(1);
      end else begin
         sum_next   = sum_ff;
         count_next = count_ff;
      end
   end

   assign div_trial = {div_rem_ff, div_quo_ff[SUM_W-1]};
   assign div_take  = (div_trial >= {1'b0, div_den_ff});

   assign sq_try = sq_res_ff + sq_bit_ff;
   assign root   = sq_res_ff[LW-1:0];
   assign dev    = (root >= arlt_pkg::MIDSCALE_Q4) ? (root - arlt_pkg::MIDSCALE_Q4)
                                                   : (arlt_pkg::MIDSCALE_Q4 - root);
   assign noise_q4 = {noise_floor_ff, 4'b0000};

   // history length: zero acts as one, clamp to the memory depth
   always_comb begin
      if (hist_len_ff == '0) begin
         len_eff = FILL_W'(1);
      end else if (int'(hist_len_ff) > HISTORY_DEPTH) begin
         len_eff = LEN_MAX;
      end else begin
         len_eff = FILL_W'(hist_len_ff);
      end
   end

   assign used       = (fill_ff < len_eff) ? fill_ff : len_eff;
   assign newest_inc = (newest_ff == PTR_LAST) ? '0 : newest_ff + PTR_W'(1);
   assign fill_inc   = {1'b0, fill_ff} + (FILL_W + 1)'(1);

   assign xi     = level_ff[LW-1:4];
   assign mn     = lo_ff[LW-1:4];
   assign hi_int = hi_ff[LW-1:4];
   assign mx     = (hi_int < min_max_ff) ? min_max_ff : hi_int;
   assign span   = mx - mn;
   assign numer  = (xi - mn) * arlt_pkg::FULL_BRIGHT;

   assign mem_rd = (state_ff == arlt_pkg::ST_WALK) && (walk_left_ff != '0);
   assign mem_wr = (state_ff == arlt_pkg::ST_PUSH);

   // ---------------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      noise_floor_in = noise_floor_ff;
      min_max_in     = min_max_ff;
      hist_len_in    = hist_len_ff;
      sum_in         = sum_ff;
      count_in       = count_ff;
      div_rem_in     = div_rem_ff;
      div_quo_in     = div_quo_ff;
      div_den_in     = div_den_ff;
      div_cnt_in     = div_cnt_ff;
      div_bright_in  = div_bright_ff;
      sq_val_in      = sq_val_ff;
      sq_res_in      = sq_res_ff;
      sq_bit_in      = sq_bit_ff;
      level_in       = level_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      louder_in      = louder_ff;
      bright_in      = bright_ff;
      newest_in      = newest_ff;
      fill_in        = fill_ff;
      walk_ptr_in    = walk_ptr_ff;
      walk_left_in   = walk_left_ff;
      pend_in        = 1'b0;
      first_in       = first_ff;
      started_in     = started_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_level_in   = rsp_level_ff;
      rsp_bright_in  = rsp_bright_ff;
      rsp_louder_in  = rsp_louder_ff;

      if (csr_write) begin
         case (csr_index)
            arlt_pkg::REG_NOISE_FLOOR: noise_floor_in = csr_pwdata[SW-1:0];
            arlt_pkg::REG_MIN_MAX:     min_max_in     = csr_pwdata[SW-1:0];
            arlt_pkg::REG_HIST_LEN:    hist_len_in    = csr_pwdata[arlt_pkg::HLEN_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         arlt_pkg::ST_IDLE: begin
            if (in_accept) begin
               sum_in   = sum_next;
               count_in = count_next;
               if (req_tlast) begin
                  // mean square = sum / count
                  div_rem_in    = '0;
                  div_quo_in    = sum_next;
                  div_den_in    = DIV_W'(count_next);
                  div_cnt_in    = DCNT_W'(SUM_W);
                  div_bright_in = 1'b0;
                  state_in      = arlt_pkg::ST_DIV;
               end
            end
         end
         arlt_pkg::ST_DIV: begin
            div_rem_in = div_take ? DIV_W'(div_trial - {1'b0, div_den_ff})
                                  : div_trial[DIV_W-1:0];
            div_quo_in = {div_quo_ff[SUM_W-2:0], div_take};
            div_cnt_in = div_cnt_ff - DCNT_W'(1);
            if (div_cnt_ff == DCNT_W'(1)) begin
               if (div_bright_ff) begin
                  bright_in = (div_quo_in[SUM_W-1:BW] != '0) ? arlt_pkg::FULL_BRIGHT
                                                             : div_quo_in[BW-1:0];
                  state_in  = arlt_pkg::ST_PUSH;
               end else begin
                  // mean fits 20 bits; scale by 256 for 4 root fraction bits
                  sq_val_in = {div_quo_in[RAD_W-9:0], 8'h00};
                  sq_res_in = '0;
                  sq_bit_in = BIT_TOP;
                  state_in  = arlt_pkg::ST_SQRT;
               end
            end
         end
         arlt_pkg::ST_SQRT: begin
            if (sq_val_ff >= sq_try) begin
               sq_val_in = sq_val_ff - sq_try;
               sq_res_in = (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_in = sq_res_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
            if (sq_bit_ff[0] || sq_bit_ff[1]) begin
               state_in = arlt_pkg::ST_LEVEL;
            end
         end
         arlt_pkg::ST_LEVEL: begin
            level_in     = (dev <= noise_q4) ? '0 : (dev - noise_q4);
            lo_in        = level_in;
            hi_in        = level_in;
            louder_in    = 1'b1;
            walk_ptr_in  = newest_ff;
            walk_left_in = used;
            started_in   = 1'b0;
            state_in     = arlt_pkg::ST_WALK;
         end
         arlt_pkg::ST_WALK: begin
            // issue one read per cycle, newest entry first
            if (mem_rd) begin
               walk_ptr_in  = (walk_ptr_ff == '0) ? PTR_LAST : walk_ptr_ff - PTR_W'(1);
               walk_left_in = walk_left_ff - FILL_W'(1);
               pend_in      = 1'b1;
               first_in     = !started_ff;
               started_in   = 1'b1;
            end
            if (pend_ff) begin
               if (mem_q_ff < lo_ff) lo_in = mem_q_ff;
               if (mem_q_ff > hi_ff) hi_in = mem_q_ff;
               if (first_ff) louder_in = (level_ff > mem_q_ff);
            end
            if (!mem_rd && !pend_ff) begin
               state_in = arlt_pkg::ST_SCALE;
            end
         end
         arlt_pkg::ST_SCALE: begin
            if (mx > mn) begin
               div_rem_in    = '0;
               div_quo_in    = SUM_W'(numer);
               div_den_in    = DIV_W'(span);
               div_cnt_in    = DCNT_W'(SUM_W);
               div_bright_in = 1'b1;
               state_in      = arlt_pkg::ST_DIV;
            end else begin
               bright_in = '0;
               state_in  = arlt_pkg::ST_PUSH;
            end
         end
         arlt_pkg::ST_PUSH: begin
            newest_in = newest_inc;
            fill_in   = (fill_inc > {1'b0, len_eff}) ? len_eff : fill_inc[FILL_W-1:0];
            sum_in    = '0;
            count_in  = '0;
            state_in  = arlt_pkg::ST_DONE;
         end
         arlt_pkg::ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_level_in  = level_ff;
               rsp_bright_in = bright_ff;
               rsp_louder_in = louder_ff;
               state_in      = arlt_pkg::ST_IDLE;
            end
         end
         default: state_in = arlt_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= arlt_pkg::ST_IDLE;
         noise_floor_ff <= '0;
         min_max_ff     <= '0;
         hist_len_ff    <= arlt_pkg::HLEN_RESET;
         sum_ff         <= '0;
         count_ff       <= '0;
         newest_ff      <= '0;
         fill_ff        <= '0;
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         noise_floor_ff <= noise_floor_in;
         min_max_ff     <= min_max_in;
         hist_len_ff    <= hist_len_in;
         sum_ff         <= sum_in;
         count_ff       <= count_in;
         newest_ff      <= newest_in;
         fill_ff        <= fill_in;
         pend_ff        <= pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_rem_ff    <= div_rem_in;
      div_quo_ff    <= div_quo_in;
      div_den_ff    <= div_den_in;
      div_cnt_ff    <= div_cnt_in;
      div_bright_ff <= div_bright_in;
      sq_val_ff     <= sq_val_in;
      sq_res_ff     <= sq_res_in;
      sq_bit_ff     <= sq_bit_in;
      level_ff      <= level_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      louder_ff     <= louder_in;
      bright_ff     <= bright_in;
      walk_ptr_ff   <= walk_ptr_in;
      walk_left_ff  <= walk_left_in;
      first_ff      <= first_in;
      started_ff    <= started_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_bright_ff <= rsp_bright_in;
      rsp_louder_ff <= rsp_louder_in;
   end

   // level history memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         hist_mem[newest_inc] <= level_ff;
      end
      if (mem_rd) begin
         mem_q_ff <= hist_mem[walk_ptr_ff];
      end
   end

   // ---------------------------------------------------------------------------
   // Outputs
   // ---------------------------------------------------------------------------
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_bright_ff, rsp_level_ff};
   assign rsp_tuser  = rsp_louder_ff;

   always_comb begin
      case (csr_index)
         arlt_pkg::REG_NOISE_FLOOR: csr_prdata = {{(arlt_pkg::CSR_DATA_W - SW){1'b0}},
                                                  noise_floor_ff};
         arlt_pkg::REG_MIN_MAX:     csr_prdata = {{(arlt_pkg::CSR_DATA_W - SW){1'b0}},
                                                  min_max_ff};
         arlt_pkg::REG_HIST_LEN:    csr_prdata = {{(arlt_pkg::CSR_DATA_W -
                                                    arlt_pkg::HLEN_W){1'b0}}, hist_len_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LEN_MAX)
      else $error("history fill beyond memory depth");

   a_window_end_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("window-end transaction did not start the sequence");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (state_ff == arlt_pkg::ST_PUSH) |=> (fill_ff != '0) && (count_ff == '0))
      else $error("push left history empty or accumulators set");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == arlt_pkg::ST_WALK) |-> (walk_left_ff <= len_eff))
      else $error("history walk longer than history length");

endmodule

[test/tb_audio_rms_level_tracker.sv]
`timescale 1ns / 100ps

module tb_audio_rms_level_tracker;

   // One sample transaction on the request side
   typedef struct packed {
      logic [arlt_pkg::SAMPLE_W-1:0] sample;
      logic                          last;
   } sample_txn_type;

   // One window reading on the result side
   typedef struct packed {
      logic [arlt_pkg::LEVEL_W-1:0]  level;
      logic [arlt_pkg::BRIGHT_W-1:0] brightness;
      logic                          louder;
   } reading_type;

   localparam int HIST_SLOTS  = arlt_pkg::HISTORY_DEPTH_DEF;
   localparam int COUNT_LIMIT = arlt_pkg::MAX_WINDOW_SAMPLES_DEF;
   localparam logic [arlt_pkg::SUM_W-1:0] SUM_CEIL = '1;
   // idle time after a drain, ample for the window-end sequence to finish
   localparam int SETTLE_CYCLES    = 200;
   localparam int SHOWN_MISMATCHES = 10;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_tvalid  = 1'b0;
   logic                            req_tready;
   logic [15:0]                     req_tdata   = '0;    // [9:0] sample
   logic                            req_tlast   = 1'b0;  // last_of_window
   logic                            rsp_tvalid;
   logic                            rsp_tready  = 1'b0;
   logic [23:0]                     rsp_tdata;           // [13:0] level, [21:14] brightness
   logic                            rsp_tuser;           // [0] louder
   logic                            csr_psel    = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite  = 1'b0;
   logic [arlt_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [arlt_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [arlt_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   audio_rms_level_tracker dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Level predictor: register mirror, window accumulators and level history
   // ---------------------------------------------------------------------------
   logic [9:0]                    floor_cfg    = '0;
   logic [9:0]                    top_min_cfg  = '0;
   logic [arlt_pkg::HLEN_W-1:0]   hist_len_cfg = arlt_pkg::HLEN_RESET;

   logic [arlt_pkg::SUM_W-1:0]    sum_of_squares = '0;
   int unsigned                   window_count   = 0;
   logic [arlt_pkg::LEVEL_W-1:0]  level_log [HIST_SLOTS];
   int unsigned                   log_fill       = 0;
   int unsigned                   log_newest     = 0;

   sample_txn_type     pending_samples [$];
   reading_type        expected_readings [$];

   int                 idle_pct         = 0;
   int                 samples_taken    = 0;
   int                 readings_checked = 0;
   int                 settings_applied = 0;
   int                 mismatches       = 0;

   // Integer square root, one result bit per pair of input bits
   function automatic int unsigned root_of(int unsigned v);
      int unsigned res;
      int unsigned probe;
      res   = 0;
      probe = 32'h4000_0000;
      while (probe > v)
         probe >>= 2;
      while (probe != 0) begin
         if (v >= res + probe) begin
            v   -= res + probe;
            res  = (res >> 1) + probe;
         end else begin
            res >>= 1;
         end
         probe >>= 2;
      end
      return res;
   endfunction

   // Fold one accepted sample into the window; on window end queue the reading
   function automatic void absorb_sample(sample_txn_type txn);
      logic [63:0] wide;
      int unsigned mean, root, dev, floor_q4, lvl, span_len, used;
      int unsigned lo, hi, idx, xi, mn, mx, bright, k;
      reading_type want;
      // hold the sum once the count is full, but the window still ends on tlast
      if (window_count < COUNT_LIMIT) begin
         wide = 64'(sum_of_squares) + 64'(txn.sample) * 64'(txn.sample);
         sum_of_squares = (wide > 64'(SUM_CEIL)) ? SUM_CEIL : wide[arlt_pkg::SUM_W-1:0];
         window_count++;
      end
      if (!txn.last)
         return;

      mean     = (window_count != 0) ? 32'(64'(sum_of_squares) / 64'(window_count)) : 0;
      root     = root_of(mean << 8);
      dev      = (root >= arlt_pkg::MIDSCALE_Q4) ? root - arlt_pkg::MIDSCALE_Q4
                                                 : arlt_pkg::MIDSCALE_Q4 - root;
      floor_q4 = 32'(floor_cfg) << 4;
      lvl      = (dev <= floor_q4) ? 0 : dev - floor_q4;

      // a zero length acts as one, anything past the depth as the depth
      span_len = (hist_len_cfg == 0) ? 1 :
                 (hist_len_cfg > HIST_SLOTS) ? HIST_SLOTS : 32'(hist_len_cfg);
      used     = (log_fill < span_len) ? log_fill : span_len;
      lo       = lvl;
      hi       = lvl;
      idx      = log_newest;
      for (k = 0; k < used; k++) begin
         if (level_log[idx] < lo) lo = level_log[idx];
         if (level_log[idx] > hi) hi = level_log[idx];
         idx = (idx == 0) ? HIST_SLOTS - 1 : idx - 1;
      end
      xi = lvl >> 4;
      mn = lo >> 4;
      mx = hi >> 4;
      if (mx < top_min_cfg)
         mx = top_min_cfg;
      bright = 0;
      if (mx > mn && xi >= mn) begin
         bright = ((xi - mn) * arlt_pkg::FULL_BRIGHT) / (mx - mn);
         if (bright > arlt_pkg::FULL_BRIGHT)
            bright = arlt_pkg::FULL_BRIGHT;
      end

      want.level      = arlt_pkg::LEVEL_W'(lvl);
      want.brightness = arlt_pkg::BRIGHT_W'(bright);
      want.louder     = (log_fill == 0) ? 1'b1 : (lvl > level_log[log_newest]);
      expected_readings.push_back(want);

      // push the level; shrink the fill to a lowered history length
      log_newest            = (log_newest + 1) % HIST_SLOTS;
      level_log[log_newest] = arlt_pkg::LEVEL_W'(lvl);
      log_fill              = (log_fill + 1 > span_len) ? span_len : log_fill + 1;
      sum_of_squares        = '0;
      window_count          = 0;
   endfunction

   // ---------------------------------------------------------------------------
   // Sample driver: pop pending transactions, insert random idle bursts
   // ---------------------------------------------------------------------------
   sample_txn_type in_flight;
   int             send_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         // predict on the edge that accepts the transaction
         if (req_tvalid && req_tready) begin
            absorb_sample(in_flight);
            samples_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_samples.size() != 0 && idle_pct != 0 &&
                         $urandom_range(99, 0) < idle_pct) begin
               // idle burst: this cycle plus send_gap further idle cycles
               send_gap = $urandom_range(12, 0);
               req_tvalid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
               in_flight = pending_samples.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= 16'(in_flight.sample);
               req_tlast  <= in_flight.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Reading monitor: stall at random, compare against the oldest expectation
   // ---------------------------------------------------------------------------
   int          hold_left = 0;
   reading_type seen_reading;
   reading_type wanted_reading;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen_reading.level      = rsp_tdata[13:0];
            seen_reading.brightness = rsp_tdata[21:14];
            seen_reading.louder     = rsp_tuser;
            readings_checked++;
            if (expected_readings.size() == 0) begin
               if (mismatches < SHOWN_MISMATCHES)
                  $display("unexpected reading: level %0d brightness %0d louder %0d",
                           seen_reading.level, seen_reading.brightness, seen_reading.louder);
               mismatches++;
            end else begin
               wanted_reading = expected_readings.pop_front();
               if (seen_reading.level !== wanted_reading.level ||
                   seen_reading.brightness !== wanted_reading.brightness ||
                   seen_reading.louder !== wanted_reading.louder) begin
                  if (mismatches < SHOWN_MISMATCHES)
                     $display({"reading %0d mismatch: level exp %0d got %0d, ",
                               "brightness exp %0d got %0d, louder exp %0d got %0d"},
                              readings_checked, wanted_reading.level, seen_reading.level,
                              wanted_reading.brightness, seen_reading.brightness,
                              wanted_reading.louder, seen_reading.louder);
                  mismatches++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
            hold_left = $urandom_range(12, 0);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus and register sequencing
   // ---------------------------------------------------------------------------
   function automatic void queue_sample(int unsigned value, bit last);
      sample_txn_type txn;
      txn.sample = arlt_pkg::SAMPLE_W'(value);
      txn.last   = last;
      pending_samples.push_back(txn);
   endfunction

   // Queue whole windows of random length and loudness until the budget is spent
   task automatic queue_random_windows(input int budget);
      int queued, wlen, mode, amp, k, value;
      queued = 0;
      while (queued < budget) begin
         wlen = ($urandom_range(7, 0) == 0) ? $urandom_range(100, 41) : $urandom_range(24, 1);
         mode = $urandom_range(9, 0);
         amp  = $urandom_range(511, 0);
         for (k = 0; k < wlen; k++) begin
            case (mode)
               0: value = $urandom_range(1023, 0);
               1: value = $urandom_range(1, 0) ? 1023 : 0;
               2: value = 512;
               default: value = 512 - amp + $urandom_range(2 * amp, 0);
            endcase
            queue_sample(value, k == wlen - 1);
         end
         queued += wlen;
      end
   endtask

   // Wait until every queued transaction is accepted and every reading is back
   task automatic drain();
      do @(negedge clock);
      while (pending_samples.size() != 0 || req_tvalid || expected_readings.size() != 0);
   endtask

   // Drain, then give the block time to finish its window-end sequence
   task automatic settle();
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Setup cycle, access cycle, then release the bus
   task automatic write_register(input logic [1:0] which, input int unsigned value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {which, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (which)
         arlt_pkg::REG_NOISE_FLOOR: floor_cfg    = 10'(value);
         arlt_pkg::REG_MIN_MAX:     top_min_cfg  = 10'(value);
         arlt_pkg::REG_HIST_LEN:    hist_len_cfg = arlt_pkg::HLEN_W'(value);
         default: ;
      endcase
   endtask

   task automatic apply_setting(input int unsigned noise, input int unsigned top_min,
                                input int unsigned hist_len);
      settle();
      write_register(arlt_pkg::REG_NOISE_FLOOR, noise);
      write_register(arlt_pkg::REG_MIN_MAX, top_min);
      write_register(arlt_pkg::REG_HIST_LEN, hist_len);
      settings_applied++;
   endtask

   initial begin
      int k;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      idle_pct = 20;

      // Directed windows under reset settings: empty history, level extremes,
      // midscale silence, alternating bit patterns and a repeated level.
      queue_sample(0, 1);            // full-scale deviation, first window
      queue_sample(1023, 1);
      queue_sample(512, 1);          // zero deviation
      queue_sample(0, 0);
      queue_sample(1023, 0);
      queue_sample(512, 1);
      queue_sample(10'h2AA, 0);
      queue_sample(10'h155, 1);
      queue_sample(511, 0);
      queue_sample(513, 1);
      queue_sample(700, 1);
      queue_sample(700, 1);          // equal to the previous level: not louder
      for (k = 0; k < 5; k++)
         queue_sample(512, k == 4);
      settle();
      queue_random_windows(250);

      // Noise floor and top bound of 512, single-entry history
      apply_setting(512, 512, 1);
      queue_random_windows(200);

      // Zero history length; hold the sender mid-window until all readings return
      apply_setting(37, 200, 0);
      queue_random_windows(100);
      for (k = 0; k < 7; k++)
         queue_sample($urandom_range(1023, 0), 0);
      drain();
      queue_random_windows(100);

      // History length past the depth, no idling for a stretch
      apply_setting(0, 0, 31);
      idle_pct = 0;
      queue_random_windows(200);

      // Shorter history after a full one
      apply_setting(100, 20, 4);
      idle_pct = 35;
      queue_random_windows(100);

      apply_setting(5, 300, 16);
      idle_pct = 15;
      queue_random_windows(250);

      // Closing part runs at full rate on both sides
      apply_setting(0, 512, 8);
      idle_pct = 0;
      queue_random_windows(200);

      settle();
      $display("Covered %0d samples closing %0d windows across %0d register settings.",
               samples_taken, readings_checked, settings_applied + 1);
      $display("Included noise and top-bound extremes and history lengths 0 to 31.");
      if (mismatches == 0 && expected_readings.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog: a correct run finishes far sooner
   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

[audio_rms_level_tracker.f]
sv/arlt_pkg.sv
sv/audio_rms_level_tracker.sv
test/tb_audio_rms_level_tracker.sv
